// ----- rtl/core/lphs_pkg.sv -----
// Shared types and constants for the linear probing hash set.
package lphs_pkg;

  localparam int KEY_W          = 32;
  localparam int SLOT_W         = 10;
  localparam int TABLE_SIZE_DEF = 1024;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } lphs_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_PROBE
  } lphs_state_t;

endpackage

// ----- rtl/core/lphs_mem.sv -----
// Slot table: one write port, one registered read port.
module lphs_mem #(
  parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF,
  parameter int AW         = $clog2(TABLE_SIZE)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  lphs_pkg::lphs_entry_t wdata,
  input  logic [AW-1:0]       raddr,
  output lphs_pkg::lphs_entry_t rdata
);
  import lphs_pkg::*;

  lphs_entry_t mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lphs_mod.sv -----
// Residue of a signed key mod TABLE_SIZE by reciprocal multiplication, subtract and correction.
module lphs_mod #(
  parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF,
  parameter int AW         = $clog2(TABLE_SIZE)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output logic                      done,
  output logic [AW-1:0]             rem
);
  import lphs_pkg::*;

  localparam int               SH      = KEY_W + AW - 1;
  localparam logic [63:0]      RECIP64 = (64'd1 << SH) / 64'(TABLE_SIZE);
  localparam logic [KEY_W-1:0] RECIP   = RECIP64[KEY_W-1:0];
  localparam logic [KEY_W-1:0] MODK    = KEY_W'(TABLE_SIZE);
  localparam logic [63:0]      WRAP64  = (64'd1 << KEY_W) % 64'(TABLE_SIZE);
  localparam logic [AW:0]      WRAP    = WRAP64[AW:0];
  localparam logic [AW:0]      MODV    = (AW+1)'(TABLE_SIZE);

  logic               busy;
  logic [1:0]         step;
  logic [KEY_W-1:0]   sreg;
  logic               neg;
  logic [KEY_W-1:0]   quo;
  logic [KEY_W-1:0]   qm;
  logic [AW:0]        part;
  logic [AW-1:0]      r;
  logic [2*KEY_W-1:0] prod;
  logic [KEY_W-1:0]   diff;
  logic [AW:0]        red;
  logic [AW:0]        rx;
  logic [AW:0]        fix;

  // quotient estimate is low by at most one, so one subtract finishes the residue;
  // a negative key then takes off 2^32 mod TABLE_SIZE
  always_comb begin
    prod = {{KEY_W{1'b0}}, sreg} * {{KEY_W{1'b0}}, RECIP};
    diff = sreg - qm;
    red  = (part >= MODV) ? part - MODV : part;
    rx   = {1'b0, red[AW-1:0]};
    fix  = (rx >= WRAP) ? rx - WRAP : rx + MODV - WRAP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        sreg <= key;
        neg  <= key[KEY_W-1];
      end else if (busy) begin
        step <= step + 1'b1;
        unique case (step)
          2'd0: quo  <= KEY_W'(prod >> SH);
          2'd1: qm   <= quo * MODK;
          2'd2: part <= diff[AW:0];
          2'd3: begin
            busy <= 1'b0;
            done <= 1'b1;
            r    <= neg ? fix[AW-1:0] : red[AW-1:0];
          end
        endcase
      end
    end
  end

  assign rem = r;

endmodule

// ----- rtl/core/linear_probing_hash_set.sv -----
// Top level of the linear probing hash set: probe sequencer, slot table, result register.
//
//   channel   valid          ready          payload
//   item      item_valid     item_ready     command, key
//   result    result_valid   result_ready   found, stored, table_full, slot
//
// One word per item. An item takes 1..TABLE_SIZE probes, one slot at a time, as set by the
// single table read port and the one key comparator. A TABLE_SIZE that is not a power of
// two first runs the residue unit. After reset a clearing pass over all TABLE_SIZE slots
// runs with item_ready low. A stalled result holds the final probe until the result register
// frees; the next item is taken while a result waits.
module linear_probing_hash_set #(
  parameter int TABLE_SIZE = lphs_pkg::TABLE_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        command,
  input  logic signed [lphs_pkg::KEY_W-1:0] key,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        found,
  output logic                        stored,
  output logic                        table_full,
  output logic [lphs_pkg::SLOT_W-1:0] slot
);
  import lphs_pkg::*;

  localparam int AW   = $clog2(TABLE_SIZE);
  localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  lphs_state_t      state, state_next;
  logic [AW-1:0]    pos, pos_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic [AW-1:0]    pos_inc;
  logic [KEY_W-1:0] key_q;
  logic             cmd_q;

  logic             we;
  lphs_entry_t      wdata;
  logic [AW-1:0]    raddr;
  lphs_entry_t      rdata;

  logic             mod_start;
  logic             mod_done;
  logic [AW-1:0]    mod_rem;

  logic             hit, empty, res_load, res_full, res_stored;

  lphs_mem #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (pos),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  lphs_mod #(.TABLE_SIZE(TABLE_SIZE), .AW(AW)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign item_ready = (state == ST_IDLE);
  assign pos_inc    = (pos == LAST) ? '0 : pos + 1'b1;
  assign hit        = rdata.valid && (rdata.key == key_q);
  assign empty      = !rdata.valid;

  always_comb begin
    state_next = state;
    pos_next   = pos;
    cnt_next   = cnt;
    raddr      = pos;
    we         = 1'b0;
    wdata      = '{valid: 1'b0, key: key_q};
    mod_start  = 1'b0;
    res_load   = 1'b0;
    res_stored = 1'b0;
    res_full   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        pos_next = pos_inc;
        if (pos == LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          if (POW2) begin
            pos_next   = key[AW-1:0];
            raddr      = key[AW-1:0];
            cnt_next   = '0;
            state_next = ST_PROBE;
          end else begin
            mod_start  = 1'b1;
            state_next = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        if (mod_done) begin
          pos_next   = mod_rem;
          raddr      = mod_rem;
          cnt_next   = '0;
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit || empty || cnt == LAST) begin
          if (!result_valid || result_ready) begin
            res_load   = 1'b1;
            res_stored = empty && (cmd_q == CMD_INSERT);
            res_full   = !hit && !empty;
            we         = res_stored;
            wdata      = '{valid: 1'b1, key: key_q};
            state_next = ST_IDLE;
          end
        end else begin
          pos_next = pos_inc;
          raddr    = pos_inc;
          cnt_next = cnt + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      pos          <= '0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      key_q <= key;
      cmd_q <= command;
    end
    if (res_load) begin
      found      <= hit;
      stored     <= res_stored;
      table_full <= res_full;
      slot       <= (hit || res_stored) ? SLOT_W'(pos) : '0;
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({found, stored, table_full}))
    else $error("result flags not exclusive");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && we) |-> (cmd_q == CMD_INSERT))
    else $error("query wrote the table");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found && !stored) |-> (slot == '0))
    else $error("slot set without hit or store");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while busy");

endmodule
